// ===== hdl/pcr_pkg.sv =====
// Package: widths, outcome codes and shared types for the pair collision block
`timescale 1ns / 1ps
`default_nettype none
package pcr_pkg;
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int RW        = 31;
  localparam int EW        = 17;
  localparam logic [16:0] REST_ONE = 17'd65536;
  localparam logic [33:0] X_THRESHOLD = 34'((64'd1 << FRAC_BITS) / 100);
  localparam logic [33:0] X_NUDGE     = 34'((64'd1 << FRAC_BITS) / 10);

  typedef enum logic [1:0] {
    OUT_RESOLVED   = 2'd0,
    OUT_COINCIDENT = 2'd1,
    OUT_SEPARATING = 2'd2
  } outcome_t;

  // One pair of bodies as it travels down the pipe
  typedef struct packed {
    logic signed [DW-1:0] apx, apy, avx, avy;
    logic [RW-1:0]        ar;
    logic signed [DW-1:0] bpx, bpy, bvx, bvy;
    logic [RW-1:0]        br;
  } pair_t;

  // Side-band width carried alongside the root and divider pipes
  localparam int TAG_W = $bits(pair_t) + 34 + 2 + 2 * 35;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[DW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/pcr_sqrt.sv =====
// Pipelined truncating square root, two result bits per stage
`timescale 1ns / 1ps
`default_nettype none
module pcr_sqrt import pcr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [67:0]      radicand,
  input  wire logic [TAG_W-1:0] in_tag,
  output logic                  out_valid,
  output logic [33:0]           root,
  output logic [TAG_W-1:0]      out_tag
);
  localparam int STEPS = 34;
  localparam int PER = 2;
  localparam int NST = STEPS / PER;

  logic [NST:0]       vld;
  logic [67:0]        rad  [NST+1];
  logic [35:0]        rem  [NST+1];
  logic [33:0]        rt   [NST+1];
  logic [TAG_W-1:0]   tg   [NST+1];

  always_comb begin
    rad[0] = radicand;
    rem[0] = '0;
    rt[0]  = '0;
    tg[0]  = in_tag;
    vld[0] = in_valid;
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [35:0] rem_c [PER+1];
    logic [33:0] rt_c  [PER+1];
    always_comb begin
      rem_c[0] = rem[s];
      rt_c[0]  = rt[s];
      for (int k = 0; k < PER; k++) begin
        logic [35:0] r2;
        logic [35:0] trial;
        r2 = {rem_c[k][33:0], rad[s][67 - 2*(s*PER+k) -: 2]};
        trial = {rt_c[k], 2'b01};
        if (r2 >= trial) begin
          rem_c[k+1] = r2 - trial;
          rt_c[k+1]  = {rt_c[k][32:0], 1'b1};
        end else begin
          rem_c[k+1] = r2;
          rt_c[k+1]  = {rt_c[k][32:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else vld[s+1] <= vld[s];
      rad[s+1] <= rad[s];
      rem[s+1] <= rem_c[PER];
      rt[s+1]  <= rt_c[PER];
      tg[s+1]  <= tg[s];
    end
  end

  assign out_valid = vld[NST];
  assign root      = rt[NST];
  assign out_tag   = tg[NST];
endmodule
`default_nettype wire

// ===== hdl/pcr_div.sv =====
// Pipelined restoring divider: (|num| << FRAC_BITS) / den, sign applied at the end
`timescale 1ns / 1ps
`default_nettype none
module pcr_div import pcr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [34:0] num,
  input  wire logic [33:0]        den,
  input  wire logic [TAG_W-1:0]   in_tag,
  output logic                    out_valid,
  output logic signed [34:0]      quot,
  output logic [TAG_W-1:0]        out_tag
);
  // |num| < 2^34 so the dividend is at most 50 bits; one quotient bit per step
  localparam int NB = 34 + FRAC_BITS;
  localparam int PER = 4;
  localparam int NST = (NB + PER - 1) / PER;
  localparam int QB = NST * PER;

  logic [NST:0]     vld;
  logic [QB-1:0]    dvd [NST+1];
  logic [34:0]      rem [NST+1];
  logic [33:0]      dn  [NST+1];
  logic             neg [NST+1];
  logic [TAG_W-1:0] tg  [NST+1];
  logic [33:0]      mag_in;

  assign mag_in = num[34] ? 34'(-num) : num[33:0];

  always_comb begin
    vld[0] = in_valid;
    dvd[0] = QB'({mag_in, {FRAC_BITS{1'b0}}});
    rem[0] = '0;
    dn[0]  = den;
    neg[0] = num[34];
    tg[0]  = in_tag;
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [34:0]   rc [PER+1];
    logic [QB-1:0] qc [PER+1];
    always_comb begin
      rc[0] = rem[s];
      qc[0] = dvd[s];
      for (int k = 0; k < PER; k++) begin
        logic [35:0] r2;
        r2 = {rc[k], qc[k][QB-1]};
        if (r2 >= {2'b00, dn[s]}) begin
          rc[k+1] = 35'(r2 - {2'b00, dn[s]});
          qc[k+1] = {qc[k][QB-2:0], 1'b1};
        end else begin
          rc[k+1] = r2[34:0];
          qc[k+1] = {qc[k][QB-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else vld[s+1] <= vld[s];
      dvd[s+1] <= qc[PER];
      rem[s+1] <= rc[PER];
      dn[s+1]  <= dn[s];
      neg[s+1] <= neg[s];
      tg[s+1]  <= tg[s];
    end
  end

  // quotient fits in 34 bits since |num| <= den up to rounding of the root
  assign out_valid = vld[NST];
  assign quot      = neg[NST] ? -$signed({1'b0, dvd[NST][33:0]})
                              : $signed({1'b0, dvd[NST][33:0]});
  assign out_tag   = tg[NST];
endmodule
`default_nettype wire

// ===== hdl/pair_collision_resolve.sv =====
// Top level: streaming collision resolution for two equal-mass circles
//
//  channel   | handshake         | beat
//  ----------+-------------------+-----------------------------------------
//  command   | start / busy      | positions, velocities, radii of a pair
//  result    | done (strobe)     | new_* fields and outcome
//  config    | restitution_we    | restitution_wdata (17 bit Q1.16)
//
// One pair enters per cycle; busy is always low once out of reset.
// The pipeline holds two square roots (17 stages each), two divider banks
// (13 stages each) and ten single register stages.
// Synchronous reset clears all valid bits and sets restitution to 1.0.
// The receiver cannot stall, so no stall path exists.
`timescale 1ns / 1ps
`default_nettype none
module pair_collision_resolve import pcr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 restitution_we,
  input  wire logic [EW-1:0]        restitution_wdata,
  input  wire logic signed [DW-1:0] first_pos_x,
  input  wire logic signed [DW-1:0] first_pos_y,
  input  wire logic signed [DW-1:0] first_vel_x,
  input  wire logic signed [DW-1:0] first_vel_y,
  input  wire logic [RW-1:0]        first_radius,
  input  wire logic signed [DW-1:0] second_pos_x,
  input  wire logic signed [DW-1:0] second_pos_y,
  input  wire logic signed [DW-1:0] second_vel_x,
  input  wire logic signed [DW-1:0] second_vel_y,
  input  wire logic [RW-1:0]        second_radius,
  output logic                      done,
  output logic signed [DW-1:0]      new_first_pos_x,
  output logic signed [DW-1:0]      new_first_pos_y,
  output logic signed [DW-1:0]      new_first_vel_x,
  output logic signed [DW-1:0]      new_first_vel_y,
  output logic signed [DW-1:0]      new_second_pos_x,
  output logic signed [DW-1:0]      new_second_pos_y,
  output logic signed [DW-1:0]      new_second_vel_x,
  output logic signed [DW-1:0]      new_second_vel_y,
  output logic [1:0]                outcome
);
  localparam int PW = $bits(pair_t);

  logic [EW-1:0] restitution;
  always_ff @(posedge clk) begin
    if (rst) restitution <= REST_ONE;
    else if (restitution_we) restitution <= restitution_wdata;
  end

  assign busy = rst;

  // Stages A and B: centre difference, then squares
  pair_t              p_in;
  logic               a_v;
  pair_t              a_p;
  logic signed [32:0] a_dx, a_dy;
  always_comb begin
    p_in = '{first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
             second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius};
  end
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else a_v <= start && !busy;
    a_p  <= p_in;
    a_dx <= 33'(first_pos_x) - 33'(second_pos_x);
    a_dy <= 33'(first_pos_y) - 33'(second_pos_y);
  end

  logic        b_v;
  pair_t       b_p;
  logic signed [32:0] b_dx, b_dy;
  logic [65:0] b_sx, b_sy;
  logic [32:0] a_mx, a_my;
  assign a_mx = a_dx[32] ? 33'(-a_dx) : 33'(a_dx);
  assign a_my = a_dy[32] ? 33'(-a_dy) : 33'(a_dy);
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else b_v <= a_v;
    b_p <= a_p; b_dx <= a_dx; b_dy <= a_dy;
    b_sx <= 66'(a_mx) * 66'(a_mx);
    b_sy <= 66'(a_my) * 66'(a_my);
  end

  // distance square root
  localparam int T1 = PW + 66;
  logic             s1_v;
  logic [33:0]      s1_root;
  logic [TAG_W-1:0] s1_tag;
  pcr_sqrt u_sqrt1 (
    .clk(clk), .rst(rst), .in_valid(b_v),
    .radicand(68'(b_sx) + 68'(b_sy)),
    .in_tag(TAG_W'({b_p, b_dx, b_dy})),
    .out_valid(s1_v), .root(s1_root), .out_tag(s1_tag));

  pair_t              c_p;
  logic signed [32:0] c_dx, c_dy;
  assign {c_p, c_dx, c_dy} = s1_tag[T1-1:0];
  logic c_zero;
  assign c_zero = (s1_root == '0);

  // first normal: two dividers side by side, side-band split between them
  logic               d1_v, d1_v2;
  logic signed [34:0] d1_nx, d1_ny;
  logic [TAG_W-1:0]   d1_tag_p, d1_tag_d;
  logic [33:0]        den1;
  assign den1 = c_zero ? 34'd1 : s1_root;
  pcr_div u_div_nx (
    .clk(clk), .rst(rst), .in_valid(s1_v), .num(35'(c_dx)), .den(den1),
    .in_tag(TAG_W'(c_p)),
    .out_valid(d1_v), .quot(d1_nx), .out_tag(d1_tag_p));
  pcr_div u_div_ny (
    .clk(clk), .rst(rst), .in_valid(s1_v), .num(35'(c_dy)), .den(den1),
    .in_tag(TAG_W'({s1_root, c_zero})),
    .out_valid(d1_v2), .quot(d1_ny), .out_tag(d1_tag_d));

  pair_t       e_p;
  logic [33:0] e_dist;
  logic        e_zero;
  assign e_p = d1_tag_p[PW-1:0];
  assign {e_dist, e_zero} = d1_tag_d[34:0];

  // nudge test, then squares for the renormalising length
  logic               f_v;
  pair_t              f_p;
  logic [33:0]        f_dist;
  logic               f_zero, f_nudge;
  logic signed [34:0] f_nx, f_ny;
  logic [34:0]        e_mnx;
  assign e_mnx = d1_nx[34] ? 35'(-d1_nx) : 35'(d1_nx);
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else f_v <= d1_v && d1_v2;
    f_p <= e_p; f_dist <= e_dist; f_zero <= e_zero;
    f_nudge <= (e_mnx < 35'(X_THRESHOLD));
    f_nx <= (e_mnx < 35'(X_THRESHOLD)) ? d1_nx + $signed(35'(X_NUDGE)) : d1_nx;
    f_ny <= d1_ny;
  end

  logic               g_v;
  pair_t              g_p;
  logic [33:0]        g_dist;
  logic               g_zero, g_nudge;
  logic signed [34:0] g_nx, g_ny;
  logic [65:0]        g_sx, g_sy;
  logic [32:0]        f_mx, f_my;
  assign f_mx = f_nx[34] ? 33'(-f_nx) : 33'(f_nx);
  assign f_my = f_ny[34] ? 33'(-f_ny) : 33'(f_ny);
  always_ff @(posedge clk) begin
    if (rst) g_v <= 1'b0;
    else g_v <= f_v;
    g_p <= f_p; g_dist <= f_dist; g_zero <= f_zero; g_nudge <= f_nudge;
    g_nx <= f_nx; g_ny <= f_ny;
    g_sx <= 66'(f_mx) * 66'(f_mx);
    g_sy <= 66'(f_my) * 66'(f_my);
  end

  logic             s2_v;
  logic [33:0]      s2_root;
  logic [TAG_W-1:0] s2_tag;
  pcr_sqrt u_sqrt2 (
    .clk(clk), .rst(rst), .in_valid(g_v),
    .radicand(68'(g_sx) + 68'(g_sy)),
    .in_tag({g_p, g_dist, g_zero, g_nudge, g_nx, g_ny}),
    .out_valid(s2_v), .root(s2_root), .out_tag(s2_tag));

  pair_t              h_p;
  logic [33:0]        h_dist;
  logic               h_zero, h_nudge;
  logic signed [34:0] h_nx, h_ny;
  assign {h_p, h_dist, h_zero, h_nudge, h_nx, h_ny} = s2_tag;
  logic h_re;
  assign h_re = h_nudge && (s2_root != '0);

  // second normal: renormalise where nudged, else the divider is bypassed via tag
  logic               d2_v, d2_v2;
  logic signed [34:0] d2_nx, d2_ny;
  logic [TAG_W-1:0]   d2_tag_p, d2_tag_d;
  logic [33:0]        den2;
  assign den2 = h_re ? s2_root : 34'd1;
  pcr_div u_div_rx (
    .clk(clk), .rst(rst), .in_valid(s2_v), .num(h_nx), .den(den2),
    .in_tag(TAG_W'(h_p)),
    .out_valid(d2_v), .quot(d2_nx), .out_tag(d2_tag_p));
  pcr_div u_div_ry (
    .clk(clk), .rst(rst), .in_valid(s2_v), .num(h_ny), .den(den2),
    .in_tag(TAG_W'({h_dist, h_zero, h_re, h_nx, h_ny})),
    .out_valid(d2_v2), .quot(d2_ny), .out_tag(d2_tag_d));

  pair_t              i_p;
  logic [33:0]        i_dist;
  logic               i_zero, i_re;
  logic signed [34:0] i_ox, i_oy;
  assign i_p = d2_tag_p[PW-1:0];
  assign {i_dist, i_zero, i_re, i_ox, i_oy} = d2_tag_d[105:0];

  // Stage J: final normal, relative velocity, half penetration
  logic               j_v;
  pair_t              j_p;
  logic               j_zero;
  logic signed [34:0] j_nx, j_ny;
  logic signed [32:0] j_rvx, j_rvy;
  logic signed [33:0] j_half;
  logic signed [34:0] i_pen;
  assign i_pen = 35'(i_p.ar) + 35'(i_p.br) - $signed({1'b0, i_dist});
  always_ff @(posedge clk) begin
    if (rst) j_v <= 1'b0;
    else j_v <= d2_v && d2_v2;
    j_p <= i_p; j_zero <= i_zero;
    j_nx <= i_re ? d2_nx : i_ox;
    j_ny <= i_re ? d2_ny : i_oy;
    j_rvx <= 33'(i_p.avx) - 33'(i_p.bvx);
    j_rvy <= 33'(i_p.avy) - 33'(i_p.bvy);
    j_half <= i_pen[34] ? -34'(35'(-i_pen) >>> 1) : 34'(i_pen >>> 1);
  end

  // Stage K: dot product terms (33 x 35 signed)
  logic               k_v;
  pair_t              k_p;
  logic               k_zero;
  logic signed [34:0] k_nx, k_ny;
  logic signed [33:0] k_half;
  logic signed [67:0] k_tx, k_ty;
  always_ff @(posedge clk) begin
    if (rst) k_v <= 1'b0;
    else k_v <= j_v;
    k_p <= j_p; k_zero <= j_zero; k_nx <= j_nx; k_ny <= j_ny; k_half <= j_half;
    k_tx <= 68'(j_rvx) * 68'(j_nx);
    k_ty <= 68'(j_rvy) * 68'(j_ny);
  end

  // Stage L: dot sum and sign
  logic               l_v;
  pair_t              l_p;
  logic               l_zero, l_sep;
  logic signed [34:0] l_nx, l_ny;
  logic signed [33:0] l_half;
  logic [51:0]        l_vmag;
  logic signed [68:0] k_dot;
  logic [68:0]        k_mag;
  assign k_dot = 69'(k_tx) + 69'(k_ty);
  assign k_mag = k_dot[68] ? 69'(-k_dot) : 69'(k_dot);
  always_ff @(posedge clk) begin
    if (rst) l_v <= 1'b0;
    else l_v <= k_v;
    l_p <= k_p; l_zero <= k_zero; l_nx <= k_nx; l_ny <= k_ny; l_half <= k_half;
    l_sep  <= !k_dot[68] && (k_dot != '0);
    l_vmag <= 52'(k_mag >> FRAC_BITS);
  end

  // Stage M: impulse magnitude
  logic               m_v;
  pair_t              m_p;
  logic               m_zero, m_sep;
  logic signed [34:0] m_nx, m_ny;
  logic signed [33:0] m_half;
  logic [69:0]        m_jp;
  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else m_v <= l_v;
    m_p <= l_p; m_zero <= l_zero; m_sep <= l_sep;
    m_nx <= l_nx; m_ny <= l_ny; m_half <= l_half;
    m_jp <= 70'(l_vmag) * 70'({1'b0, REST_ONE} + 18'(restitution));
  end

  // Stage N: products with the normal
  // normal components are at most 1.0, so the impulse stays below 2^35
  logic               n_v;
  pair_t              n_p;
  logic               n_zero, n_sep;
  logic signed [65:0] n_ix, n_iy, n_cx, n_cy;
  logic [34:0]        m_j;
  logic [34:0]        m_mnx, m_mny;
  logic [33:0]        m_mh;
  assign m_j   = 35'(m_jp >> 17);
  assign m_mnx = m_nx[34] ? 35'(-m_nx) : 35'(m_nx);
  assign m_mny = m_ny[34] ? 35'(-m_ny) : 35'(m_ny);
  assign m_mh  = m_half[33] ? 34'(-m_half) : 34'(m_half);
  always_ff @(posedge clk) begin
    if (rst) n_v <= 1'b0;
    else n_v <= m_v;
    n_p <= m_p; n_zero <= m_zero; n_sep <= m_sep;
    n_ix <= m_nx[34] ? -$signed(66'((70'(m_j) * 70'(m_mnx)) >> FRAC_BITS))
                     :  $signed(66'((70'(m_j) * 70'(m_mnx)) >> FRAC_BITS));
    n_iy <= m_ny[34] ? -$signed(66'((70'(m_j) * 70'(m_mny)) >> FRAC_BITS))
                     :  $signed(66'((70'(m_j) * 70'(m_mny)) >> FRAC_BITS));
    n_cx <= (m_half[33] != m_nx[34]) ? -$signed(66'((69'(m_mh) * 69'(m_mnx)) >> FRAC_BITS))
                                     :  $signed(66'((69'(m_mh) * 69'(m_mnx)) >> FRAC_BITS));
    n_cy <= (m_half[33] != m_ny[34]) ? -$signed(66'((69'(m_mh) * 69'(m_mny)) >> FRAC_BITS))
                                     :  $signed(66'((69'(m_mh) * 69'(m_mny)) >> FRAC_BITS));
  end

  // Output stage: apply, saturate, select the pass-through cases
  logic pass;
  assign pass = n_zero || n_sep;
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= n_v;
    new_first_pos_x  <= pass ? n_p.apx : sat32(66'(n_p.apx) + n_cx);
    new_first_pos_y  <= pass ? n_p.apy : sat32(66'(n_p.apy) + n_cy);
    new_first_vel_x  <= pass ? n_p.avx : sat32(66'(n_p.avx) + n_ix);
    new_first_vel_y  <= pass ? n_p.avy : sat32(66'(n_p.avy) + n_iy);
    new_second_pos_x <= pass ? n_p.bpx : sat32(66'(n_p.bpx) - n_cx);
    new_second_pos_y <= pass ? n_p.bpy : sat32(66'(n_p.bpy) - n_cy);
    new_second_vel_x <= pass ? n_p.bvx : sat32(66'(n_p.bvx) - n_ix);
    new_second_vel_y <= pass ? n_p.bvy : sat32(66'(n_p.bvy) - n_iy);
    outcome <= n_zero ? OUT_COINCIDENT : (n_sep ? OUT_SEPARATING : OUT_RESOLVED);
  end
endmodule
`default_nettype wire
